// File: rtl/assert_macros.svh
// assertion macros used by the port-level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define NRU_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, off during reset
`define NRU_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/nru_pkg.sv
// shared types and constants for the nru page replacement block
package nru_pkg;

    localparam int PAGES_DEF  = 64;
    localparam int FRAMES_DEF = 16;
    localparam int RAND_W     = 32;
    localparam int CLR_W      = 8;

    localparam logic [CLR_W-1:0] CLEAR_RESET = 8'd10;

    typedef enum logic [1:0] {
        CMD_ACCESS = 2'd0,
        CMD_SELECT = 2'd1,
        CMD_UNMAP  = 2'd2
    } t_cmd;

    typedef struct packed {
        logic present;
        logic referenced;
        logic modified;
    } t_flags;

endpackage

// File: rtl/nru_page_mem.sv
// page table memory: flags and frame per page, one write and one registered read port
module nru_page_mem #(
    parameter int PAGES = nru_pkg::PAGES_DEF,
    parameter int FW    = 4,
    localparam int AW   = $clog2(PAGES)
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [AW-1:0]        i_waddr,
    input  nru_pkg::t_flags      i_wflags,
    input  logic [FW-1:0]        i_wframe,
    input  logic [AW-1:0]        i_raddr,
    output nru_pkg::t_flags      o_rflags,
    output logic [FW-1:0]        o_rframe
);

    localparam int EW = 3 + FW;

    logic [EW-1:0] r_mem [PAGES];
    logic [EW-1:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= {i_wflags, i_wframe};
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[i_raddr];
    end

    assign o_rflags = nru_pkg::t_flags'(r_rd[EW-1:FW]);
    assign o_rframe = r_rd[FW-1:0];

endmodule

// File: rtl/nru_mod_unit.sv
// bit-serial remainder of the random value by the class count, one bit per cycle
module nru_mod_unit #(
    parameter int CW = 7
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [nru_pkg::RAND_W-1:0] i_dividend,
    input  logic [CW-1:0]              i_divisor,
    output logic                       o_done,
    output logic [CW-1:0]              o_rem
);

    localparam int SW = $clog2(nru_pkg::RAND_W);
    localparam logic [SW-1:0] STEP_LAST = SW'(nru_pkg::RAND_W - 1);

    logic                       r_busy;
    logic                       r_done;
    logic [SW-1:0]              r_step;
    logic [nru_pkg::RAND_W-1:0] r_num;
    logic [CW-1:0]              r_den;
    logic [CW-1:0]              r_rem;

    logic [CW:0]   trial;
    logic [CW:0]   diff;
    logic [CW-1:0] n_rem;

    // restoring step: remainder stays below the divisor
    always_comb begin
        trial = {r_rem, r_num[nru_pkg::RAND_W-1]};
        diff  = trial - {1'b0, r_den};
        if (trial >= {1'b0, r_den}) begin
            n_rem = diff[CW-1:0];
        end else begin
            n_rem = trial[CW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_num  <= i_dividend;
                r_den  <= i_divisor;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_num  <= {r_num[nru_pkg::RAND_W-2:0], 1'b0};
                r_rem  <= n_rem;
                r_step <= r_step + SW'(1);
                if (r_step == STEP_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// File: rtl/nru_page_replacement.sv
// top level: nru page replacement with page table memory and sweep sequencer
//
//  channel  | direction | signals                                        | moves
//  ---------+-----------+------------------------------------------------+-----------------
//  in       | in        | i_in_valid/o_in_ready, i_command..i_random_value | one command
//  out      | out       | o_out_valid/i_out_ready, o_found..o_victim_class | one result
//  cfg      | in        | i_cfg_valid/o_cfg_ready, i_cfg_data             | clear interval
//
// access passes S_RD then S_WR, read then write of one entry;
//   unmap passes S_WR only (write only), an ignored or unused command goes straight to S_DONE
// select passes S_COUNT, S_PICK, S_DIV and S_WALK, skipping S_DIV with no page present:
//   two sweeps over the memory read port, one entry a cycle, a bit-serial modulo between them
// after reset a clearing pass writes every entry with o_in_ready low
// one command at a time; a finished command waits until the output register is free
module nru_page_replacement #(
    parameter int PAGES  = nru_pkg::PAGES_DEF,
    parameter int FRAMES = nru_pkg::FRAMES_DEF,
    localparam int AW    = $clog2(PAGES),
    localparam int FW    = $clog2(FRAMES)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [1:0]                 i_command,
    input  logic [AW-1:0]              i_page,
    input  logic [FW-1:0]              i_frame,
    input  logic                       i_is_write,
    input  logic [nru_pkg::RAND_W-1:0] i_random_value,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic                       o_found,
    output logic [FW-1:0]              o_victim_frame,
    output logic [AW-1:0]              o_victim_page,
    output logic [1:0]                 o_victim_class,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [nru_pkg::CLR_W-1:0]  i_cfg_data
);

    localparam int CW = $clog2(PAGES + 1);
    localparam logic [AW-1:0] LAST     = AW'(PAGES - 1);
    localparam logic [AW:0]   PAGES_V  = (AW + 1)'(PAGES);
    localparam logic [FW:0]   FRAMES_V = (FW + 1)'(FRAMES);

    typedef enum logic [8:0] {
        S_CLEAR = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_RD    = 9'b000000100,
        S_WR    = 9'b000001000,
        S_COUNT = 9'b000010000,
        S_PICK  = 9'b000100000,
        S_DIV   = 9'b001000000,
        S_WALK  = 9'b010000000,
        S_DONE  = 9'b100000000
    } t_state;

    t_state                     r_state;
    logic [AW-1:0]              r_page;
    logic [FW-1:0]              r_frame;
    logic                       r_wr;
    logic                       r_unmap;
    logic [nru_pkg::RAND_W-1:0] r_rand;
    logic [AW-1:0]              r_addr;
    logic                       r_iss;
    logic                       r_pend;
    logic [AW-1:0]              r_pend_addr;
    logic [CW-1:0]              r_cnt [4];
    logic                       r_any;
    logic [1:0]                 r_cls;
    logic [CW-1:0]              r_pick;
    logic [CW-1:0]              r_seen;
    logic                       r_clr;
    logic [nru_pkg::CLR_W-1:0]  r_sel_cnt;
    logic [nru_pkg::CLR_W-1:0]  r_clear_int;
    logic                       r_found;
    logic [FW-1:0]              r_vframe;
    logic [AW-1:0]              r_vpage;
    logic [1:0]                 r_vclass;
    logic                       r_out_valid;
    logic                       r_o_found;
    logic [FW-1:0]              r_o_frame;
    logic [AW-1:0]              r_o_page;
    logic [1:0]                 r_o_class;

    logic [nru_pkg::CLR_W-1:0]  n_sel_cnt;
    logic                       n_any;
    logic [1:0]                 n_cls;

    logic                       in_xfer;
    logic                       out_load;
    logic                       sweep;
    logic                       last_pend;
    logic [1:0]                 rd_cls;
    logic                       match;

    logic                       mem_we;
    logic [AW-1:0]              mem_waddr;
    nru_pkg::t_flags            mem_wflags;
    logic [FW-1:0]              mem_wframe;
    logic [AW-1:0]              mem_raddr;
    nru_pkg::t_flags            rflags;
    logic [FW-1:0]              rframe;

    logic                       div_start;
    logic                       div_done;
    logic [CW-1:0]              div_rem;

    nru_page_mem #(
        .PAGES (PAGES),
        .FW    (FW)
    ) u_mem (
        .i_clk    (i_clk),
        .i_we     (mem_we),
        .i_waddr  (mem_waddr),
        .i_wflags (mem_wflags),
        .i_wframe (mem_wframe),
        .i_raddr  (mem_raddr),
        .o_rflags (rflags),
        .o_rframe (rframe)
    );

    nru_mod_unit #(
        .CW (CW)
    ) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_rand),
        .i_divisor  (r_cnt[n_cls]),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_xfer     = i_in_valid && o_in_ready;
    assign out_load    = (r_state == S_DONE) && (!r_out_valid || i_out_ready);
    assign sweep       = (r_state == S_COUNT) || (r_state == S_WALK);
    assign last_pend   = r_pend && (r_pend_addr == LAST);
    assign rd_cls      = {rflags.referenced, rflags.modified};
    assign match       = r_pend && r_any && rflags.present && (rd_cls == r_cls);
    assign n_sel_cnt   = r_sel_cnt + nru_pkg::CLR_W'(1);
    assign div_start   = (r_state == S_PICK) && n_any;

    // lowest class with any present page
    always_comb begin
        n_any = 1'b1;
        priority if (r_cnt[0] != '0) begin
            n_cls = 2'd0;
        end else if (r_cnt[1] != '0) begin
            n_cls = 2'd1;
        end else if (r_cnt[2] != '0) begin
            n_cls = 2'd2;
        end else begin
            n_cls = 2'd3;
            n_any = (r_cnt[3] != '0);
        end
    end

    // memory port selection
    always_comb begin
        mem_raddr  = (r_state == S_RD) ? r_page : r_addr;
        mem_we     = 1'b0;
        mem_waddr  = r_addr;
        mem_wflags = '0;
        mem_wframe = '0;
        unique case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
            end
            S_WR: begin
                mem_we    = 1'b1;
                mem_waddr = r_page;
                if (!r_unmap) begin
                    mem_wflags.present    = 1'b1;
                    mem_wflags.referenced = 1'b1;
                    mem_wflags.modified   = rflags.modified || r_wr;
                    mem_wframe            = r_frame;
                end
            end
            S_WALK: begin
                // on a clearing select, referenced bits are cleared behind the read sweep
                mem_we                = r_pend && r_clr;
                mem_waddr             = r_pend_addr;
                mem_wflags.present    = rflags.present;
                mem_wflags.referenced = 1'b0;
                mem_wflags.modified   = rflags.modified;
                mem_wframe            = rframe;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_addr      <= '0;
            r_iss       <= 1'b0;
            r_pend      <= 1'b0;
            r_sel_cnt   <= '0;
            r_clear_int <= nru_pkg::CLEAR_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_clear_int <= i_cfg_data;
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
                r_o_found   <= r_found;
                r_o_frame   <= r_vframe;
                r_o_page    <= r_vpage;
                r_o_class   <= r_vclass;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            // read issue and data tracking shared by both sweeps
            if (sweep) begin
                r_pend      <= r_iss;
                r_pend_addr <= r_addr;
                if (r_iss) begin
                    if (r_addr == LAST) begin
                        r_iss <= 1'b0;
                    end else begin
                        r_addr <= r_addr + AW'(1);
                    end
                end
            end

            unique case (r_state)
                S_CLEAR: begin
                    if (r_addr == LAST) begin
                        r_addr  <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_addr <= r_addr + AW'(1);
                    end
                end
                S_IDLE: begin
                    if (in_xfer) begin
                        r_page   <= i_page;
                        r_frame  <= i_frame;
                        r_wr     <= i_is_write;
                        r_rand   <= i_random_value;
                        r_found  <= 1'b0;
                        r_vframe <= '0;
                        r_vpage  <= '0;
                        r_vclass <= '0;
                        unique case (i_command)
                            nru_pkg::CMD_ACCESS: begin
                                r_unmap <= 1'b0;
                                if (({1'b0, i_page} < PAGES_V) &&
                                    ({1'b0, i_frame} < FRAMES_V)) begin
                                    r_state <= S_RD;
                                end else begin
                                    r_state <= S_DONE;
                                end
                            end
                            nru_pkg::CMD_SELECT: begin
                                r_cnt[0] <= '0;
                                r_cnt[1] <= '0;
                                r_cnt[2] <= '0;
                                r_cnt[3] <= '0;
                                r_addr   <= '0;
                                r_iss    <= 1'b1;
                                r_pend   <= 1'b0;
                                if (n_sel_cnt == r_clear_int) begin
                                    r_sel_cnt <= '0;
                                    r_clr     <= 1'b1;
                                end else begin
                                    r_sel_cnt <= n_sel_cnt;
                                    r_clr     <= 1'b0;
                                end
                                r_state <= S_COUNT;
                            end
                            nru_pkg::CMD_UNMAP: begin
                                r_unmap <= 1'b1;
                                if ({1'b0, i_page} < PAGES_V) begin
                                    r_state <= S_WR;
                                end else begin
                                    r_state <= S_DONE;
                                end
                            end
                            default: begin
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                S_RD: begin
                    r_state <= S_WR;
                end
                S_WR: begin
                    r_state <= S_DONE;
                end
                S_COUNT: begin
                    if (r_pend && rflags.present) begin
                        r_cnt[rd_cls] <= r_cnt[rd_cls] + CW'(1);
                    end
                    if (last_pend) begin
                        r_state <= S_PICK;
                    end
                end
                S_PICK: begin
                    r_cls <= n_cls;
                    r_any <= n_any;
                    if (n_any) begin
                        r_state <= S_DIV;
                    end else begin
                        r_addr  <= '0;
                        r_iss   <= 1'b1;
                        r_pend  <= 1'b0;
                        r_seen  <= '0;
                        r_state <= S_WALK;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_pick  <= div_rem;
                        r_addr  <= '0;
                        r_iss   <= 1'b1;
                        r_pend  <= 1'b0;
                        r_seen  <= '0;
                        r_state <= S_WALK;
                    end
                end
                S_WALK: begin
                    if (match) begin
                        r_seen <= r_seen + CW'(1);
                        if (r_seen == r_pick) begin
                            r_found  <= 1'b1;
                            r_vframe <= rframe;
                            r_vpage  <= r_pend_addr;
                            r_vclass <= rd_cls;
                        end
                    end
                    if (last_pend) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_found        = r_o_found;
    assign o_victim_frame = r_o_frame;
    assign o_victim_page  = r_o_page;
    assign o_victim_class = r_o_class;

endmodule

// File: rtl/nru_checker.sv
// port-level checks for the nru page replacement block, bound to the top level
`include "assert_macros.svh"

module nru_checker #(
    parameter int PAGES  = nru_pkg::PAGES_DEF,
    parameter int FRAMES = nru_pkg::FRAMES_DEF,
    localparam int AW    = $clog2(PAGES),
    localparam int FW    = $clog2(FRAMES)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          o_in_ready,
    input  logic          o_out_valid,
    input  logic          i_out_ready,
    input  logic          o_found,
    input  logic [FW-1:0] o_victim_frame,
    input  logic [AW-1:0] o_victim_page,
    input  logic [1:0]    o_victim_class
);

    localparam logic [AW:0] PAGES_V = (AW + 1)'(PAGES);

    // a result without a victim carries all zero fields
    `NRU_ASSERT_IMP(a_miss_zero, o_out_valid && !o_found, o_victim_frame == '0 && o_victim_page == '0 && o_victim_class == 2'd0, "result without victim has nonzero fields")

    // a victim page always lies in the page table
    `NRU_ASSERT_IMP(a_page_range, o_out_valid && o_found, {1'b0, o_victim_page} < PAGES_V, "victim page out of range")

    // one command in work at a time
    `NRU_ASSERT_NXT(a_one_cmd, i_in_valid && o_in_ready, !o_in_ready, "input ready right after a transfer")

    // a stalled result holds its found flag, page and frame
    `NRU_ASSERT_NXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_found) && $stable(o_victim_page) && $stable(o_victim_frame), "stalled result changed")

endmodule

bind nru_page_replacement nru_checker #(
    .PAGES  (PAGES),
    .FRAMES (FRAMES)
) u_nru_checker (.*);

// File: bench/nru_victim_checker.sv
// victim checker: tracks the page table, predicts each result and compares it on the output side
module nru_victim_checker #(
    parameter int PAGES  = nru_pkg::PAGES_DEF,
    parameter int FRAMES = nru_pkg::FRAMES_DEF,
    localparam int AW    = $clog2(PAGES),
    localparam int FW    = $clog2(FRAMES)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_in_ready,
    input  logic [1:0]                 i_command,
    input  logic [AW-1:0]              i_page,
    input  logic [FW-1:0]              i_frame,
    input  logic                       i_is_write,
    input  logic [nru_pkg::RAND_W-1:0] i_random_value,
    input  logic                       i_out_valid,
    input  logic                       i_out_ready,
    input  logic                       i_found,
    input  logic [FW-1:0]              i_victim_frame,
    input  logic [AW-1:0]              i_victim_page,
    input  logic [1:0]                 i_victim_class,
    input  logic                       i_cfg_valid,
    input  logic                       i_cfg_ready,
    input  logic [nru_pkg::CLR_W-1:0]  i_cfg_data,
    output int                         o_pending,
    output int                         o_errors
);

    typedef struct packed {
        logic          found;
        logic [FW-1:0] frame;
        logic [AW-1:0] page;
        logic [1:0]    cls;
    } t_victim;

    logic [PAGES-1:0]          present;
    logic [PAGES-1:0]          referenced;
    logic [PAGES-1:0]          modified;
    logic [FW-1:0]             frame_of [PAGES];
    logic [nru_pkg::CLR_W-1:0] select_count;
    logic [nru_pkg::CLR_W-1:0] clear_interval;
    t_victim                   results_due [$];
    int                        fail_count = 0;

    assign o_errors = fail_count;

    function automatic t_victim choose_victim(input logic [nru_pkg::RAND_W-1:0] rnd);
        t_victim     res = '0;
        int unsigned members [4];
        int unsigned pick;
        int unsigned seen;
        int          cls;
        members = '{0, 0, 0, 0};
        cls = 4;
        seen = 0;
        for (int p = 0; p < PAGES; p++) begin
            if (present[p]) begin
                members[{referenced[p], modified[p]}]++;
            end
        end
        for (int c = 3; c >= 0; c--) begin
            if (members[c] != 0) begin
                cls = c;
            end
        end
        if (cls < 4) begin
            pick = rnd % members[cls];
            for (int p = 0; p < PAGES; p++) begin
                if (present[p] && {referenced[p], modified[p]} == cls[1:0]) begin
                    if (seen == pick && !res.found) begin
                        res.found = 1'b1;
                        res.frame = frame_of[p];
                        res.page  = p[AW-1:0];
                        res.cls   = cls[1:0];
                    end
                    seen++;
                end
            end
        end
        // the clearing comes after the victim is chosen; the count wraps at 8 bits
        select_count = select_count + nru_pkg::CLR_W'(1);
        if (select_count == clear_interval) begin
            select_count = '0;
            referenced   = '0;
        end
        return res;
    endfunction

    function automatic t_victim predict_result(input logic [1:0] cmd, input logic [AW-1:0] pg,
                                               input logic [FW-1:0] frm, input logic wr,
                                               input logic [nru_pkg::RAND_W-1:0] rnd);
        t_victim res = '0;
        case (cmd)
            nru_pkg::CMD_ACCESS: begin
                present[pg]    = 1'b1;
                referenced[pg] = 1'b1;
                if (wr) begin
                    modified[pg] = 1'b1;
                end
                frame_of[pg] = frm;
            end
            nru_pkg::CMD_SELECT: begin
                res = choose_victim(rnd);
            end
            nru_pkg::CMD_UNMAP: begin
                present[pg]    = 1'b0;
                referenced[pg] = 1'b0;
                modified[pg]   = 1'b0;
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_victim got;
        t_victim want;
        t_victim due;
        if (!i_rst_n) begin
            present        = '0;
            referenced     = '0;
            modified       = '0;
            select_count   = '0;
            clear_interval = nru_pkg::CLEAR_RESET;
            for (int p = 0; p < PAGES; p++) begin
                frame_of[p] = '0;
            end
            results_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                clear_interval = i_cfg_data;
            end
            // output first: a result never belongs to a command taken at the same edge
            if (i_out_valid && i_out_ready) begin
                got = {i_found, i_victim_frame, i_victim_page, i_victim_class};
                if (results_due.size() == 0) begin
                    if (fail_count < 10) begin
                        $display("%m: result with nothing outstanding: %s%0d %s%0d %s%0d %s%0d",
                                 "found=", got.found, "frame=", got.frame,
                                 "page=", got.page, "class=", got.cls);
                    end
                    fail_count++;
                end else begin
                    want = results_due.pop_front();
                    if (got !== want) begin
                        if (fail_count < 10) begin
                            $display("%m: mismatch: expected found=%0d frame=%0d page=%0d %s%0d",
                                     want.found, want.frame, want.page, "class=", want.cls);
                            $display("%m:           got found=%0d frame=%0d page=%0d %s%0d",
                                     got.found, got.frame, got.page, "class=", got.cls);
                        end
                        fail_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                due = predict_result(i_command, i_page, i_frame, i_is_write, i_random_value);
                results_due = {results_due, due};
            end
        end
        o_pending <= results_due.size();
    end

endmodule

// File: bench/tb_nru_page_replacement.sv
// testbench top: drives commands and clear interval writes into the nru block, gives the verdict
module tb_nru_page_replacement;

    localparam int AW = $clog2(nru_pkg::PAGES_DEF);
    localparam int FW = $clog2(nru_pkg::FRAMES_DEF);
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       i_in_valid;
    logic                       o_in_ready;
    logic [1:0]                 i_command;
    logic [AW-1:0]              i_page;
    logic [FW-1:0]              i_frame;
    logic                       i_is_write;
    logic [nru_pkg::RAND_W-1:0] i_random_value;
    logic                       o_out_valid;
    logic                       i_out_ready;
    logic                       o_found;
    logic [FW-1:0]              o_victim_frame;
    logic [AW-1:0]              o_victim_page;
    logic [1:0]                 o_victim_class;
    logic                       i_cfg_valid;
    logic                       o_cfg_ready;
    logic [nru_pkg::CLR_W-1:0]  i_cfg_data;

    int pending;
    int fail_total;
    int send_run  = 0;
    int take_run  = 0;
    logic [AW-1:0] ws_base = '0;
    int            ws_span = nru_pkg::PAGES_DEF;

    always #1 i_clk = ~i_clk;

    nru_page_replacement dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_command      (i_command),
        .i_page         (i_page),
        .i_frame        (i_frame),
        .i_is_write     (i_is_write),
        .i_random_value (i_random_value),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_found        (o_found),
        .o_victim_frame (o_victim_frame),
        .o_victim_page  (o_victim_page),
        .o_victim_class (o_victim_class),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    nru_victim_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_command      (i_command),
        .i_page         (i_page),
        .i_frame        (i_frame),
        .i_is_write     (i_is_write),
        .i_random_value (i_random_value),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_found        (o_found),
        .i_victim_frame (o_victim_frame),
        .i_victim_page  (o_victim_page),
        .i_victim_class (o_victim_class),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .o_pending      (pending),
        .o_errors       (fail_total)
    );

    // random idle gap before each transfer, with occasional runs of back-to-back transfers
    function automatic int draw_wait(inout int run_left);
        if (run_left > 0) begin
            run_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            run_left = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 9);
    endfunction

    task automatic issue_command(input logic [1:0] cmd, input logic [AW-1:0] pg,
                                 input logic [FW-1:0] frm, input logic wr,
                                 input logic [nru_pkg::RAND_W-1:0] rnd);
        int gap;
        gap = draw_wait(send_run);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_command      <= cmd;
        i_page         <= pg;
        i_frame        <= frm;
        i_is_write     <= wr;
        i_random_value <= rnd;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
    endtask

    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic write_clear_interval(input logic [nru_pkg::CLR_W-1:0] interval);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= interval;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        i_cfg_valid <= 1'b0;
    endtask

    // mostly accesses and selects over the current working set, some unmaps, a few unused codes
    task automatic issue_random_command(output bit counted);
        int                         r;
        logic [1:0]                 cmd;
        logic [AW-1:0]              pg;
        logic [nru_pkg::RAND_W-1:0] rnd;
        r  = $urandom_range(0, 99);
        pg = ws_base + AW'($urandom_range(0, ws_span - 1));
        if (r < 48) begin
            cmd = nru_pkg::CMD_ACCESS;
        end else if (r < 76) begin
            cmd = nru_pkg::CMD_SELECT;
        end else if (r < 95) begin
            cmd = nru_pkg::CMD_UNMAP;
        end else begin
            cmd = CMD_UNUSED;
        end
        if ($urandom_range(0, 3) == 0) begin
            rnd = $urandom_range(0, 7);
        end else begin
            rnd = $urandom();
        end
        issue_command(cmd, pg, FW'($urandom_range(0, nru_pkg::FRAMES_DEF - 1)),
                      1'($urandom_range(0, 1)), rnd);
        counted = (cmd != CMD_UNUSED);
    endtask

    // result side: a random stall, possibly none, before each transfer, ready then held until the transfer
    initial begin : result_sink
        int stall;
        i_out_ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            stall = draw_wait(take_run);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_out_valid && i_out_ready));
        end
    end

    initial begin : stimulus
        int                        n;
        bit                        counted;
        logic [nru_pkg::CLR_W-1:0] interval;
        i_rst_n        <= 1'b0;
        i_in_valid     <= 1'b0;
        i_command      <= nru_pkg::CMD_ACCESS;
        i_page         <= '0;
        i_frame        <= '0;
        i_is_write     <= 1'b0;
        i_random_value <= '0;
        i_cfg_valid    <= 1'b0;
        i_cfg_data     <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part, clear interval at its reset value
        issue_command(nru_pkg::CMD_SELECT, 6'd0, 4'd0, 1'b0, 32'hFFFF_FFFF);   // nothing present
        issue_command(nru_pkg::CMD_UNMAP, 6'd63, 4'd15, 1'b1, 32'hFFFF_FFFF);
        issue_command(CMD_UNUSED, 6'd63, 4'd15, 1'b1, 32'hFFFF_FFFF);
        issue_command(nru_pkg::CMD_ACCESS, 6'd0, 4'd0, 1'b0, 32'h0);
        issue_command(nru_pkg::CMD_ACCESS, 6'd63, 4'd15, 1'b1, 32'hFFFF_FFFF);
        issue_command(nru_pkg::CMD_SELECT, 6'd0, 4'd0, 1'b0, 32'h0);
        issue_command(nru_pkg::CMD_ACCESS, 6'd5, 4'd9, 1'b1, 32'h0);
        issue_command(nru_pkg::CMD_SELECT, 6'd63, 4'd15, 1'b1, 32'hFFFF_FFFF);
        issue_command(nru_pkg::CMD_UNMAP, 6'd0, 4'd0, 1'b0, 32'h0);
        issue_command(nru_pkg::CMD_SELECT, 6'd0, 4'd0, 1'b0, 32'h0);            // referenced and modified class
        issue_command(nru_pkg::CMD_SELECT, 6'd0, 4'd0, 1'b0, 32'hFFFF_FFFF);
        issue_command(nru_pkg::CMD_ACCESS, 6'd63, 4'd7, 1'b0, 32'h0);           // new frame
        issue_command(nru_pkg::CMD_SELECT, 6'd0, 4'd0, 1'b0, 32'h1);
        issue_command(nru_pkg::CMD_SELECT, 6'd0, 4'd0, 1'b0, 32'h2);
        issue_command(nru_pkg::CMD_SELECT, 6'd0, 4'd0, 1'b0, 32'h3);
        issue_command(nru_pkg::CMD_SELECT, 6'd0, 4'd0, 1'b0, 32'h8000_0000);
        issue_command(nru_pkg::CMD_SELECT, 6'd0, 4'd0, 1'b0, 32'h7FFF_FFFF);    // tenth clears
        issue_command(nru_pkg::CMD_SELECT, 6'd0, 4'd0, 1'b0, 32'h0);
        issue_command(nru_pkg::CMD_ACCESS, 6'd32, 4'd8, 1'b0, 32'h0);
        issue_command(nru_pkg::CMD_SELECT, 6'd0, 4'd0, 1'b0, 32'h5555_5555);
        issue_command(nru_pkg::CMD_UNMAP, 6'd5, 4'd0, 1'b0, 32'h0);
        issue_command(nru_pkg::CMD_UNMAP, 6'd63, 4'd0, 1'b0, 32'h0);
        issue_command(nru_pkg::CMD_SELECT, 6'd0, 4'd0, 1'b0, 32'hAAAA_AAAA);
        issue_command(nru_pkg::CMD_UNMAP, 6'd32, 4'd0, 1'b0, 32'h0);
        issue_command(nru_pkg::CMD_SELECT, 6'd0, 4'd0, 1'b0, 32'h0);

        // random phases; 255 then 1 lowers the interval below the running count,
        // 0 means a clearing every 256 selects
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: interval = 8'd3;
                1: interval = 8'd255;
                2: interval = 8'd1;
                3: interval = 8'd0;
                4: interval = 8'($urandom_range(2, 254));
                default: interval = nru_pkg::CLEAR_RESET;
            endcase
            wait_for_results();
            write_clear_interval(interval);
            n = 0;
            while (n < 243) begin
                if (n % 40 == 0) begin
                    ws_base = AW'($urandom());
                    case ($urandom_range(0, 2))
                        0: ws_span = $urandom_range(1, 4);
                        1: ws_span = $urandom_range(5, 16);
                        default: ws_span = nru_pkg::PAGES_DEF;
                    endcase
                end
                if ($urandom_range(0, 99) == 0) begin
                    wait_for_results();
                end
                issue_random_command(counted);
                if (counted) begin
                    n++;
                end
            end
        end

        wait_for_results();
        repeat (200) @(posedge i_clk);
        if (fail_total == 0) begin
            $display("tb_nru_page_replacement: done, clean");
        end else begin
            $display("tb_nru_page_replacement: done, errors");
        end
        $finish;
    end

    initial begin : watchdog
        #4000000;
        $display("tb_nru_page_replacement: done, errors");
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl
rtl/nru_pkg.sv
rtl/nru_page_mem.sv
rtl/nru_mod_unit.sv
rtl/nru_page_replacement.sv
rtl/nru_checker.sv
bench/nru_victim_checker.sv
bench/tb_nru_page_replacement.sv
